// ----- sv/twq_pkg.sv -----
// twq_pkg: sizes, request and result codes and shared types of the timed wait queue
// used by twq_cell, timed_wait_queue_core and twq_checker
`timescale 1ns / 1ps

package twq_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int IDX_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

    localparam int KIND_W  = 3;
    localparam int ID_W    = 16;
    localparam int TICK_W  = 16;
    localparam int COUNT_W = 5;

    // request codes
    localparam logic [KIND_W-1:0] REQ_APPEND = 3'd0;
    localparam logic [KIND_W-1:0] REQ_REMOVE = 3'd1;
    localparam logic [KIND_W-1:0] REQ_LOOKUP = 3'd2;
    localparam logic [KIND_W-1:0] REQ_OLDEST = 3'd3;
    localparam logic [KIND_W-1:0] REQ_TICK   = 3'd4;

    // result codes
    localparam logic [KIND_W-1:0] RES_APPENDED  = 3'd0;
    localparam logic [KIND_W-1:0] RES_FULL      = 3'd1;
    localparam logic [KIND_W-1:0] RES_FOUND     = 3'd2;
    localparam logic [KIND_W-1:0] RES_NOT_FOUND = 3'd3;
    localparam logic [KIND_W-1:0] RES_RELEASED  = 3'd4;
    localparam logic [KIND_W-1:0] RES_TICK_DONE = 3'd5;

    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic [TICK_W-1:0] timer;
    } t_entry;

    typedef struct packed {
        logic   shift;
        logic   wr_sel;
        t_entry wr_data;
    } t_cell_ctl;

endpackage

// ----- sv/timed_wait_queue_core.sv -----
// timed_wait_queue_core: top level of the timed wait queue, sequencer and slot chain
// depends on twq_pkg and twq_cell
`timescale 1ns / 1ps

// Usage
// Input channel: i_in_valid / o_in_stall carry one request (kind, thread id, wait ticks).
// Output channel: o_out_valid / i_out_stall carry results; o_last marks the final
// result of a request. Requests are handled one at a time; o_in_stall is high while
// one is in progress. Kinds 5 to 7 are taken and dropped with no result.
// Append: the result is registered in the append state once the output register is free.
// Remove by id, look up, remove oldest and tick: the slot chain shifts one entry
// past the head per cycle, except while a release waits for the output register,
// and the final result is registered in the done state after the pass. Kept entries re-enter behind the
// unvisited ones, so the queue is packed again when the pass ends.
// The next request can be taken while the final result of the previous one is on the output.
// A tick emits one released result per expired entry during the pass, then the
// tick done result with the count.
// A stalled output holds its result; the pass waits whenever it must emit while
// the output register is still occupied.
// Reset empties the queue and clears the output valid flag; slot contents are not
// cleared, occupancy alone says which slots hold entries.

module timed_wait_queue_core (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic [twq_pkg::KIND_W-1:0]  i_kind,
    input  logic [twq_pkg::ID_W-1:0]    i_thread_id,
    input  logic [twq_pkg::TICK_W-1:0]  i_wait_ticks,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic [twq_pkg::KIND_W-1:0]  o_result_kind,
    output logic [twq_pkg::ID_W-1:0]    o_thread_id_res,
    output logic [twq_pkg::COUNT_W-1:0] o_release_count,
    output logic                        o_last
);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_APPEND = 2'd1;
    localparam logic [1:0] S_SWEEP  = 2'd2;
    localparam logic [1:0] S_DONE   = 2'd3;

    logic [1:0] r_state, n_state;
    logic [twq_pkg::KIND_W-1:0] r_kind, n_kind;
    logic [twq_pkg::ID_W-1:0]   r_id, n_id;
    logic [twq_pkg::TICK_W-1:0] r_ticks, n_ticks;
    logic [twq_pkg::ID_W-1:0]   r_res_id, n_res_id;
    logic [twq_pkg::CNT_W-1:0]  r_occ, n_occ;
    logic [twq_pkg::CNT_W-1:0]  r_rem, n_rem;
    logic [twq_pkg::CNT_W-1:0]  r_kept, n_kept;
    logic [twq_pkg::CNT_W-1:0]  r_count, n_count;
    logic                       r_hit, n_hit;

    logic                          r_out_valid, n_out_valid;
    logic [twq_pkg::KIND_W-1:0]    r_out_kind, n_out_kind;
    logic [twq_pkg::ID_W-1:0]      r_out_id, n_out_id;
    logic [twq_pkg::COUNT_W-1:0]   r_out_count, n_out_count;
    logic                          r_out_last, n_out_last;

    logic                      w_accept;
    logic                      w_out_free;
    logic                      w_shift;
    logic                      w_wr_en;
    logic [twq_pkg::IDX_W-1:0] w_wr_idx;
    twq_pkg::t_entry           w_wr_data;
    twq_pkg::t_entry           w_head;
    logic [twq_pkg::CNT_W-1:0] w_tail_pos;
    logic                      w_match;
    logic                      w_drop;
    logic                      w_release;
    logic [twq_pkg::TICK_W-1:0] w_new_timer;

    twq_pkg::t_cell_ctl w_ctl   [twq_pkg::QUEUE_DEPTH];
    twq_pkg::t_entry    w_entry [twq_pkg::QUEUE_DEPTH];
    twq_pkg::t_entry    w_next  [twq_pkg::QUEUE_DEPTH];

    assign o_in_stall = (r_state != S_IDLE);
    assign w_accept   = i_in_valid && (r_state == S_IDLE);
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_head     = w_entry[0];
    // slot behind the unvisited entries and the ones already kept, after this shift
    assign w_tail_pos = r_rem - 1'b1 + r_kept;

    // what the pass does with the head entry
    always_comb begin
        w_match     = 1'b0;
        w_release   = 1'b0;
        w_new_timer = w_head.timer;
        unique case (r_kind)
            twq_pkg::REQ_REMOVE,
            twq_pkg::REQ_LOOKUP: w_match = !r_hit && (w_head.id == r_id);
            twq_pkg::REQ_OLDEST: w_match = !r_hit;
            twq_pkg::REQ_TICK: begin
                if (w_head.timer != '0) begin
                    w_new_timer = w_head.timer - 1'b1;
                end
                w_release = (w_head.timer == twq_pkg::TICK_W'(1));
            end
            default: ;
        endcase
        w_drop = w_release ||
                 (w_match && ((r_kind == twq_pkg::REQ_REMOVE) ||
                              (r_kind == twq_pkg::REQ_OLDEST)));
    end

    always_comb begin
        n_state     = r_state;
        n_kind      = r_kind;
        n_id        = r_id;
        n_ticks     = r_ticks;
        n_res_id    = r_res_id;
        n_occ       = r_occ;
        n_rem       = r_rem;
        n_kept      = r_kept;
        n_count     = r_count;
        n_hit       = r_hit;
        n_out_valid = r_out_valid && i_out_stall;
        n_out_kind  = r_out_kind;
        n_out_id    = r_out_id;
        n_out_count = r_out_count;
        n_out_last  = r_out_last;
        w_shift     = 1'b0;
        w_wr_en     = 1'b0;
        w_wr_idx    = w_tail_pos[twq_pkg::IDX_W-1:0];
        w_wr_data   = '{id: w_head.id, timer: w_new_timer};

        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_kind  = i_kind;
                    n_id    = i_thread_id;
                    n_ticks = i_wait_ticks;
                    n_rem   = r_occ;
                    n_kept  = '0;
                    n_count = '0;
                    n_hit   = 1'b0;
                    priority if (i_kind == twq_pkg::REQ_APPEND) begin
                        n_state = S_APPEND;
                    end else if ((i_kind == twq_pkg::REQ_REMOVE) ||
                                 (i_kind == twq_pkg::REQ_LOOKUP) ||
                                 (i_kind == twq_pkg::REQ_OLDEST) ||
                                 (i_kind == twq_pkg::REQ_TICK)) begin
                        n_state = S_SWEEP;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_APPEND: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_out_id    = r_id;
                    n_out_count = '0;
                    n_out_last  = 1'b1;
                    if (r_occ == twq_pkg::CNT_W'(twq_pkg::QUEUE_DEPTH)) begin
                        n_out_kind = twq_pkg::RES_FULL;
                    end else begin
                        n_out_kind = twq_pkg::RES_APPENDED;
                        w_wr_en    = 1'b1;
                        w_wr_idx   = r_occ[twq_pkg::IDX_W-1:0];
                        w_wr_data  = '{id: r_id, timer: r_ticks};
                        n_occ      = r_occ + 1'b1;
                    end
                    n_state = S_IDLE;
                end
            end
            S_SWEEP: begin
                if (r_rem == '0) begin
                    n_state = S_DONE;
                end else if (!w_release || w_out_free) begin
                    w_shift = 1'b1;
                    w_wr_en = !w_drop;
                    n_rem   = r_rem - 1'b1;
                    n_kept  = r_kept + twq_pkg::CNT_W'(!w_drop);
                    n_count = r_count + twq_pkg::CNT_W'(w_release);
                    if (w_match) begin
                        n_hit    = 1'b1;
                        n_res_id = w_head.id;
                    end
                    if (w_release) begin
                        n_out_valid = 1'b1;
                        n_out_kind  = twq_pkg::RES_RELEASED;
                        n_out_id    = w_head.id;
                        n_out_count = '0;
                        n_out_last  = 1'b0;
                    end
                end
            end
            S_DONE: begin
                if (w_out_free) begin
                    n_occ       = r_kept;
                    n_out_valid = 1'b1;
                    n_out_last  = 1'b1;
                    n_out_count = '0;
                    priority if (r_kind == twq_pkg::REQ_TICK) begin
                        n_out_kind  = twq_pkg::RES_TICK_DONE;
                        n_out_id    = '0;
                        n_out_count = twq_pkg::COUNT_W'(r_count);
                    end else if (r_hit) begin
                        n_out_kind = twq_pkg::RES_FOUND;
                        n_out_id   = r_res_id;
                    end else begin
                        n_out_kind = twq_pkg::RES_NOT_FOUND;
                        n_out_id   = '0;
                    end
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_occ       <= '0;
            r_rem       <= '0;
            r_kept      <= '0;
            r_count     <= '0;
            r_hit       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_occ       <= n_occ;
            r_rem       <= n_rem;
            r_kept      <= n_kept;
            r_count     <= n_count;
            r_hit       <= n_hit;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind      <= n_kind;
        r_id        <= n_id;
        r_ticks     <= n_ticks;
        r_res_id    <= n_res_id;
        r_out_kind  <= n_out_kind;
        r_out_id    <= n_out_id;
        r_out_count <= n_out_count;
        r_out_last  <= n_out_last;
    end

    // slot chain: slot i loads from slot i+1 on a shift
    for (genvar g = 0; g < twq_pkg::QUEUE_DEPTH; g++) begin : g_cell
        assign w_ctl[g].shift   = w_shift;
        assign w_ctl[g].wr_sel  = w_wr_en && (w_wr_idx == twq_pkg::IDX_W'(g));
        assign w_ctl[g].wr_data = w_wr_data;

        if (g == twq_pkg::QUEUE_DEPTH - 1) begin : g_tail
            assign w_next[g] = '0;
        end else begin : g_link
            assign w_next[g] = w_entry[g+1];
        end

        twq_cell u_cell (
            .i_clk   (i_clk),
            .i_ctl   (w_ctl[g]),
            .i_next  (w_next[g]),
            .o_entry (w_entry[g])
        );
    end

    assign o_out_valid     = r_out_valid;
    assign o_result_kind   = r_out_kind;
    assign o_thread_id_res = r_out_id;
    assign o_release_count = r_out_count;
    assign o_last          = r_out_last;

endmodule

// ----- sv/twq_cell.sv -----
// twq_cell: one queue slot, loads from the next slot on a shift or takes a direct write
// depends on twq_pkg
`timescale 1ns / 1ps

module twq_cell (
    input  logic               i_clk,
    input  twq_pkg::t_cell_ctl i_ctl,
    input  twq_pkg::t_entry    i_next,
    output twq_pkg::t_entry    o_entry
);

    twq_pkg::t_entry r_entry;

    // a direct write wins over the shift from the neighbor
    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_sel) begin
            r_entry <= i_ctl.wr_data;
        end else if (i_ctl.shift) begin
            r_entry <= i_next;
        end
    end

    assign o_entry = r_entry;

endmodule

// ----- sv/twq_checker.sv -----
// twq_checker: port-level assertions on timed_wait_queue_core, bound to the top level
// depends on twq_pkg and timed_wait_queue_core
`timescale 1ns / 1ps

module twq_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        o_out_valid,
    input logic                        i_out_stall,
    input logic [twq_pkg::KIND_W-1:0]  o_result_kind,
    input logic [twq_pkg::ID_W-1:0]    o_thread_id_res,
    input logic [twq_pkg::COUNT_W-1:0] o_release_count,
    input logic                        o_last
);

    // no result right after reset
    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

    // a stalled result transaction holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_result_kind) &&
            $stable(o_thread_id_res) && $stable(o_release_count) && $stable(o_last))
        else $error("stalled result changed");

    // only released results are not last
    a_last_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_last == (o_result_kind != twq_pkg::RES_RELEASED)))
        else $error("last flag does not match result kind");

    // count is carried by tick done only
    a_count_only_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_result_kind != twq_pkg::RES_TICK_DONE) |-> o_release_count == '0)
        else $error("release count on a result other than tick done");

    // not found and tick done carry id zero
    a_zero_id: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && ((o_result_kind == twq_pkg::RES_NOT_FOUND) ||
                        (o_result_kind == twq_pkg::RES_TICK_DONE))
            |-> o_thread_id_res == '0)
        else $error("nonzero id on not found or tick done");

endmodule

bind timed_wait_queue_core twq_checker u_twq_checker (.*);

// ----- sim/testbench.sv -----
`timescale 1ns / 1ps
// testbench: self-checking bench for timed_wait_queue_core, a directed table then random requests
// depends on twq_pkg and timed_wait_queue_core; expected results come from a queue model kept here

module testbench;
    import twq_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 40;
    localparam int RANDOM_ITEMS = 120;
    localparam int HOLD_AFTER   = 40;
    localparam int HOLD_CYCLES  = 300;
    localparam int MAX_PRINTED  = 40;

    // kinds the block takes and drops without a result
    localparam logic [KIND_W-1:0] REQ_RESERVED_LO = 3'd5;
    localparam logic [KIND_W-1:0] REQ_RESERVED_HI = 3'd7;

    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [ID_W-1:0]    id;
        logic [COUNT_W-1:0] count;
        logic               last;
    } t_result;

    typedef struct {
        logic [KIND_W-1:0] kind;
        logic [ID_W-1:0]   id;
        logic [TICK_W-1:0] ticks;
        int                reps;
        bit                typed;
        t_result           res;
    } t_row;

    typedef enum int {SINK_OPEN, SINK_RANDOM, SINK_PERIODIC, SINK_HEAVY} t_sink_mode;

    logic                i_clk           = 1'b0;
    logic                i_rst_n         = 1'b0;
    logic                i_in_valid      = 1'b0;
    logic [KIND_W-1:0]   i_kind          = '0;
    logic [ID_W-1:0]     i_thread_id     = '0;
    logic [TICK_W-1:0]   i_wait_ticks    = '0;
    logic                i_out_stall     = 1'b0;
    logic                o_in_stall;
    logic                o_out_valid;
    logic [KIND_W-1:0]   o_result_kind;
    logic [ID_W-1:0]     o_thread_id_res;
    logic [COUNT_W-1:0]  o_release_count;
    logic                o_last;

    // queue model
    logic [ID_W-1:0]     model_id    [QUEUE_DEPTH];
    logic [TICK_W-1:0]   model_timer [QUEUE_DEPTH];
    int                  model_count = 0;

    t_result             step_results[$];
    t_result             expected_results[$];

    int  cycle_count    = 0;
    int  error_count    = 0;
    int  requests_sent  = 0;
    int  random_sent    = 0;
    int  results_seen   = 0;
    int  released_seen  = 0;
    int  full_seen      = 0;
    int  peak_occupancy = 0;
    int  burst_left     = 0;
    int  append_bias    = 40;
    bit  hold_active    = 1'b0;

    t_row directed_rows [14] = '{
        '{REQ_LOOKUP, 16'h0000, 16'h0000, 1, 1'b1, '{RES_NOT_FOUND, 16'h0000, 5'd0, 1'b1}},
        '{REQ_OLDEST, 16'h0000, 16'h0000, 1, 1'b1, '{RES_NOT_FOUND, 16'h0000, 5'd0, 1'b1}},
        '{REQ_TICK,   16'h0000, 16'h0000, 1, 1'b1, '{RES_TICK_DONE, 16'h0000, 5'd0, 1'b1}},
        '{REQ_REMOVE, 16'hFFFF, 16'h0000, 1, 1'b1, '{RES_NOT_FOUND, 16'h0000, 5'd0, 1'b1}},
        '{REQ_APPEND, 16'h0000, 16'h0000, 1, 1'b1, '{RES_APPENDED,  16'h0000, 5'd0, 1'b1}},
        '{REQ_APPEND, 16'hFFFF, 16'hFFFF, 1, 1'b1, '{RES_APPENDED,  16'hFFFF, 5'd0, 1'b1}},
        '{REQ_APPEND, 16'h1234, 16'h0001, 1, 1'b1, '{RES_APPENDED,  16'h1234, 5'd0, 1'b1}},
        '{REQ_RESERVED_HI, 16'hFFFF, 16'hFFFF, 1, 1'b0, '0},
        '{REQ_LOOKUP, 16'h1234, 16'h0000, 1, 1'b0, '0},
        '{REQ_TICK,   16'h0000, 16'h0000, 1, 1'b0, '0},
        '{REQ_REMOVE, 16'hFFFF, 16'h0000, 1, 1'b0, '0},
        '{REQ_OLDEST, 16'h0000, 16'h0000, 1, 1'b0, '0},
        // fill past the top, then release every entry in one tick
        '{REQ_APPEND, 16'h5555, 16'h0001, QUEUE_DEPTH + 1, 1'b0, '0},
        '{REQ_TICK,   16'h0000, 16'h0000, 1, 1'b0, '0}
    };

    timed_wait_queue_core DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_kind          (i_kind),
        .i_thread_id     (i_thread_id),
        .i_wait_ticks    (i_wait_ticks),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_result_kind   (o_result_kind),
        .o_thread_id_res (o_thread_id_res),
        .o_release_count (o_release_count),
        .o_last          (o_last)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
    end

    task automatic report_error(input string msg);
        error_count++;
        if (error_count <= MAX_PRINTED) begin
            $display("[cycle %0d] mismatch: %s", cycle_count, msg);
        end
    endtask

    task automatic drop_entry(input int pos);
        for (int i = pos; i + 1 < model_count; i++) begin
            model_id[i]    = model_id[i + 1];
            model_timer[i] = model_timer[i + 1];
        end
        model_count--;
    endtask

    // updates the model for one accepted request and leaves its results in step_results
    task automatic predict_request(input logic [KIND_W-1:0] kind, input logic [ID_W-1:0] id,
                                   input logic [TICK_W-1:0] ticks);
        int                pos;
        int                wr;
        int                released;
        logic [TICK_W-1:0] t;
        logic [ID_W-1:0]   head;
        step_results.delete();
        case (kind)
            REQ_APPEND: begin
                if (model_count >= QUEUE_DEPTH) begin
                    step_results.push_back('{RES_FULL, id, '0, 1'b1});
                    full_seen++;
                end else begin
                    model_id[model_count]    = id;
                    model_timer[model_count] = ticks;
                    model_count++;
                    step_results.push_back('{RES_APPENDED, id, '0, 1'b1});
                end
            end
            REQ_REMOVE, REQ_LOOKUP: begin
                pos = model_count;
                for (int i = model_count - 1; i >= 0; i--) begin
                    if (model_id[i] == id) pos = i;
                end
                if (pos < model_count) begin
                    if (kind == REQ_REMOVE) drop_entry(pos);
                    step_results.push_back('{RES_FOUND, id, '0, 1'b1});
                end else begin
                    step_results.push_back('{RES_NOT_FOUND, '0, '0, 1'b1});
                end
            end
            REQ_OLDEST: begin
                if (model_count == 0) begin
                    step_results.push_back('{RES_NOT_FOUND, '0, '0, 1'b1});
                end else begin
                    head = model_id[0];
                    drop_entry(0);
                    step_results.push_back('{RES_FOUND, head, '0, 1'b1});
                end
            end
            REQ_TICK: begin
                wr       = 0;
                released = 0;
                for (int rd = 0; rd < model_count; rd++) begin
                    t = model_timer[rd];
                    // zero timeout waits forever
                    if (t != '0) t = t - 1'b1;
                    if (model_timer[rd] != '0 && t == '0) begin
                        step_results.push_back('{RES_RELEASED, model_id[rd], '0, 1'b0});
                        released++;
                    end else begin
                        model_id[wr]    = model_id[rd];
                        model_timer[wr] = t;
                        wr++;
                    end
                end
                model_count = wr;
                step_results.push_back('{RES_TICK_DONE, '0, COUNT_W'(released), 1'b1});
            end
            default: ;
        endcase
        if (model_count > peak_occupancy) peak_occupancy = model_count;
    endtask

    // offers one transaction in bursts with gaps between them; called and left at a falling edge
    task automatic issue_request(input logic [KIND_W-1:0] kind, input logic [ID_W-1:0] id,
                                 input logic [TICK_W-1:0] ticks, input bit typed,
                                 input t_result res);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 20) : $urandom_range(1, 4);
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
            burst_left = ($urandom_range(0, 4) == 0) ? 40 : $urandom_range(1, 12);
        end
        i_kind       <= kind;
        i_thread_id  <= id;
        i_wait_ticks <= ticks;
        i_in_valid   <= 1'b1;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        predict_request(kind, id, ticks);
        if (typed) begin
            expected_results.push_back(res);
        end else begin
            foreach (step_results[k]) expected_results.push_back(step_results[k]);
        end
        burst_left--;
        requests_sent++;
        @(negedge i_clk);
    endtask

    task automatic pick_random(output logic [KIND_W-1:0] kind, output logic [ID_W-1:0] id,
                               output logic [TICK_W-1:0] ticks);
        int pick;
        int sel;
        pick = $urandom_range(0, 99);
        // ids mostly from the queue or a small pool, so hits and duplicates are common
        sel = $urandom_range(0, 9);
        if (model_count > 0 && sel < 5) id = model_id[$urandom_range(0, model_count - 1)];
        else if (sel < 8) id = ID_W'(16'h0100 + $urandom_range(0, 7));
        else id = ID_W'($urandom);
        sel = $urandom_range(0, 9);
        if (sel < 2) ticks = '0;
        else if (sel < 9) ticks = TICK_W'($urandom_range(1, 6));
        else ticks = TICK_W'($urandom);
        if (pick < 4) begin
            kind = KIND_W'($urandom_range(REQ_RESERVED_LO, REQ_RESERVED_HI));
        end else if (pick < 4 + append_bias) begin
            kind = REQ_APPEND;
        end else begin
            sel = $urandom_range(0, 9);
            if (sel < 4) kind = REQ_TICK;
            else if (sel < 6) kind = REQ_REMOVE;
            else if (sel < 8) kind = REQ_LOOKUP;
            else kind = REQ_OLDEST;
        end
    endtask

    initial begin : stimulus
        logic [KIND_W-1:0] kind;
        logic [ID_W-1:0]   id;
        logic [TICK_W-1:0] ticks;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        foreach (directed_rows[r]) begin
            for (int k = 0; k < directed_rows[r].reps; k++) begin
                issue_request(directed_rows[r].kind, directed_rows[r].id, directed_rows[r].ticks,
                              directed_rows[r].typed, directed_rows[r].res);
            end
        end
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % 25 == 0) append_bias = $urandom_range(20, 70);
            pick_random(kind, id, ticks);
            issue_request(kind, id, ticks, 1'b0, '0);
            random_sent++;
        end
        i_in_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("covered %0d requests and %0d results: %0d released by timeout, %0d refused full",
                 requests_sent, results_seen, released_seen, full_seen);
        $display("queue reached %0d of %0d entries; %0d mismatches",
                 peak_occupancy, QUEUE_DEPTH, error_count);
        if (error_count == 0) $display("simulation ok");
        else $display("simulation failed");
        $finish;
    end

    // receiver stall pattern changes to a random mode after each run of random length
    initial begin : result_sink
        t_sink_mode mode;
        int         mode_left;
        int         phase;
        mode      = SINK_OPEN;
        mode_left = 0;
        phase     = 0;
        forever begin
            @(negedge i_clk);
            if (mode_left == 0) begin
                mode      = t_sink_mode'($urandom_range(0, 3));
                mode_left = $urandom_range(10, 60);
            end
            mode_left--;
            phase++;
            case (mode)
                SINK_OPEN:     i_out_stall <= hold_active;
                SINK_RANDOM:   i_out_stall <= hold_active | ($urandom_range(0, 9) < 4);
                SINK_PERIODIC: i_out_stall <= hold_active | (phase % 3 == 0);
                default:       i_out_stall <= hold_active | ($urandom_range(0, 9) < 8);
            endcase
        end
    end

    // one long receiver hold-off while requests keep coming, so the block backs up
    initial begin : long_hold
        int held;
        wait (random_sent >= HOLD_AFTER);
        @(posedge i_clk);
        hold_active = 1'b1;
        for (held = 0; held < HOLD_CYCLES; held++) @(posedge i_clk);
        hold_active = 1'b0;
    end

    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            results_seen++;
            if (expected_results.size() == 0) begin
                report_error($sformatf("unexpected result kind %0d id %h count %0d last %b",
                             o_result_kind, o_thread_id_res, o_release_count, o_last));
            end else begin
                want = expected_results.pop_front();
                if (want.kind == RES_RELEASED) released_seen++;
                if (o_result_kind !== want.kind)
                    report_error($sformatf("result_kind %0d, expected %0d",
                                 o_result_kind, want.kind));
                if (o_thread_id_res !== want.id)
                    report_error($sformatf("thread_id_res %h, expected %h",
                                 o_thread_id_res, want.id));
                if (o_release_count !== want.count)
                    report_error($sformatf("release_count %0d, expected %0d",
                                 o_release_count, want.count));
                if (o_last !== want.last)
                    report_error($sformatf("last %b, expected %b", o_last, want.last));
            end
        end
    end

    initial begin : watchdog
        wait (cycle_count >= CYCLE_LIMIT);
        $display("timeout after %0d cycles, %0d results still outstanding",
                 cycle_count, expected_results.size());
        $display("simulation failed");
        $finish;
    end

endmodule

// ----- filelist.f -----
sv/twq_pkg.sv
sv/twq_cell.sv
sv/timed_wait_queue_core.sv
sv/twq_checker.sv
sim/testbench.sv
